// ----- rtl/nru_replacement_policy_unit_defines.svh -----
// Assertion macros for the NRU replacement policy unit.
// Depends on a clock named clk and an active-low reset named rst_n in the user module.
`ifndef NRU_REPLACEMENT_POLICY_UNIT_DEFINES_SVH
`define NRU_REPLACEMENT_POLICY_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define NRU_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define NRU_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/nru_pkg.sv -----
// Shared types and constants of the NRU replacement policy unit.
// No dependencies; used by every RTL module and interface.
`default_nettype none

package nru_pkg;

    localparam int NUM_BLOCKS_DEF = 64;
    localparam int REQ_TYPE_W     = 3;
    localparam int BLK_W          = 6;
    localparam int CLS_W          = 3;
    localparam int PERIOD_W       = 16;
    localparam int SCAN_LANES     = 8;
    localparam int CMD_DEPTH      = 2;
    localparam int PTR_W          = $clog2(CMD_DEPTH);
    localparam int CNT_W          = $clog2(CMD_DEPTH + 1);

    // bit positions of the marks inside a class code
    localparam int REFER = 1;
    localparam int MODIF = 0;

    localparam logic [CLS_W-1:0] CLS_NONE = 3'd4;

    localparam logic [REQ_TYPE_W-1:0] REQ_READ       = 3'd0;
    localparam logic [REQ_TYPE_W-1:0] REQ_WRITE      = 3'd1;
    localparam logic [REQ_TYPE_W-1:0] REQ_INVALIDATE = 3'd2;
    localparam logic [REQ_TYPE_W-1:0] REQ_VICTIM     = 3'd3;
    localparam logic [REQ_TYPE_W-1:0] REQ_SET_DIRTY  = 3'd4;

    typedef enum logic [1:0] {
        OP_ACCESS,
        OP_CLEAR,
        OP_VICTIM,
        OP_DIRTY
    } nru_op_t;

    typedef struct packed {
        nru_op_t          op;
        logic [BLK_W-1:0] blk;
        logic             dirty;
    } nru_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } nru_fifo_stat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PUSH
    } nru_state_t;

endpackage

`default_nettype wire

// ----- rtl/nru_if.sv -----
// Request and response channel interfaces of the NRU replacement policy unit.
// Depends on nru_pkg for field widths.
`default_nettype none

interface nru_req_if
    import nru_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [REQ_TYPE_W-1:0] req_type;
    logic [BLK_W-1:0]      block_index;
    logic                  dirty_value;

    modport source (output valid, req_type, block_index, dirty_value, input ready);
    modport sink   (input valid, req_type, block_index, dirty_value, output ready);
endinterface

interface nru_rsp_if
    import nru_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [BLK_W-1:0] victim_index;
    logic [1:0]       victim_class;

    modport source (output valid, victim_index, victim_class, input ready);
    modport sink   (input valid, victim_index, victim_class, output ready);
endinterface

`default_nettype wire

// ----- rtl/nru_front.sv -----
// Front end: accepts request beats, drops unused codes and out-of-range blocks,
// and turns the rest into queue commands. Depends on nru_pkg and nru_req_if.
`default_nettype none

module nru_front
    import nru_pkg::*;
#(
    parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
    nru_req_if.sink         req,
    input  nru_fifo_stat_t  stat,
    output logic            push,
    output nru_cmd_t        cmd
);

    logic keep;
    logic in_range;

    assign in_range = (int'(req.block_index) < NUM_BLOCKS);

    always_comb
    begin
        cmd.blk   = req.block_index;
        cmd.dirty = req.dirty_value;
        cmd.op    = OP_ACCESS;
        keep      = 1'b0;
        unique case (req.req_type)
            REQ_READ, REQ_WRITE:
            begin
                cmd.op = OP_ACCESS;
                keep   = in_range;
            end
            REQ_INVALIDATE:
            begin
                cmd.op = OP_CLEAR;
                keep   = 1'b1;
            end
            REQ_VICTIM:
            begin
                cmd.op = OP_VICTIM;
                keep   = 1'b1;
            end
            REQ_SET_DIRTY:
            begin
                cmd.op = OP_DIRTY;
                keep   = in_range;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign req.ready = !stat.full;
    assign push      = req.valid && !stat.full && keep;

endmodule

`default_nettype wire

// ----- rtl/nru_cmd_fifo.sv -----
// Short command queue between the front end and the back end.
// Depends on nru_pkg.
`default_nettype none

module nru_cmd_fifo
    import nru_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  nru_cmd_t       push_cmd,
    input  logic           pop,
    output nru_cmd_t       head,
    output nru_fifo_stat_t stat
);

    nru_cmd_t         slot_reg [CMD_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign stat.full  = (count_reg == CNT_W'(CMD_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/nru_back.sv -----
// Back end: holds the marks, the access counter and the period register, applies
// commands and scans for the victim a few blocks per cycle. Depends on nru_pkg,
// nru_rsp_if and the assertion macros.
`default_nettype none
`include "nru_replacement_policy_unit_defines.svh"

module nru_back
    import nru_pkg::*;
#(
    parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  nru_cmd_t            cmd,
    input  nru_fifo_stat_t      stat,
    output logic                pop,
    input  logic                cfg_wr_en,
    input  logic [PERIOD_W-1:0] cfg_wr_data,
    nru_rsp_if.source           rsp
);

    localparam int IDX_W      = $clog2(NUM_BLOCKS);
    localparam int CHUNK      = (NUM_BLOCKS < SCAN_LANES) ? NUM_BLOCKS : SCAN_LANES;
    localparam int NUM_CHUNKS = (NUM_BLOCKS + CHUNK - 1) / CHUNK;
    localparam int PADW       = NUM_CHUNKS * CHUNK;
    localparam int CW         = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
    localparam logic [PADW-1:0] LIVE = PADW'({NUM_BLOCKS{1'b1}});

    nru_state_t          state_reg, state_next;
    logic [NUM_BLOCKS-1:0] ref_reg, ref_next;
    logic [NUM_BLOCKS-1:0] mod_reg, mod_next;
    logic [PERIOD_W-1:0] cnt_reg, cnt_next;
    logic [PERIOD_W-1:0] period_reg;
    logic [CW-1:0]       chunk_reg;
    logic [CLS_W-1:0]    best_cls_reg;
    logic [IDX_W-1:0]    best_idx_reg;
    logic                out_valid_reg;
    logic [BLK_W-1:0]    out_idx_reg;
    logic [1:0]          out_cls_reg;

    logic [PERIOD_W-1:0] cnt_inc;
    logic                period_hit;
    logic [IDX_W-1:0]    blk;
    logic [PADW-1:0]     ref_pad, mod_pad;
    logic [CHUNK-1:0]    slice_ref, slice_mod, slice_live;
    logic [CLS_W-1:0]    lane_cls [CHUNK];
    logic [CLS_W-1:0]    scan_cls;
    logic [IDX_W-1:0]    scan_idx;
    logic                last_chunk, scan_done;
    logic                load_out, start_scan;

    assign blk        = IDX_W'(cmd.blk);
    assign cnt_inc    = cnt_reg + 1'b1;
    assign period_hit = (period_reg != '0) && (cnt_inc == period_reg);

    assign ref_pad    = PADW'(ref_reg);
    assign mod_pad    = PADW'(mod_reg);
    assign slice_ref  = ref_pad[chunk_reg * CHUNK +: CHUNK];
    assign slice_mod  = mod_pad[chunk_reg * CHUNK +: CHUNK];
    assign slice_live = LIVE[chunk_reg * CHUNK +: CHUNK];

    always_comb
    begin
        for (int j = 0; j < CHUNK; j++)
        begin
            lane_cls[j]        = '0;
            lane_cls[j][REFER] = slice_ref[j];
            lane_cls[j][MODIF] = slice_mod[j];
        end
    end

    always_comb
    begin
        scan_cls = best_cls_reg;
        scan_idx = best_idx_reg;
        for (int j = 0; j < CHUNK; j++)
        begin
            if (slice_live[j] && (lane_cls[j] < scan_cls))
            begin
                scan_cls = lane_cls[j];
                scan_idx = IDX_W'(int'(chunk_reg) * CHUNK + j);
            end
        end
    end

    assign last_chunk = (chunk_reg == CW'(NUM_CHUNKS - 1));
    assign scan_done  = last_chunk || (scan_cls == '0);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!stat.empty && (cmd.op == OP_VICTIM))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop        = 1'b0;
        start_scan = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                pop        = !stat.empty;
                start_scan = !stat.empty && (cmd.op == OP_VICTIM);
            end
            ST_SCAN:
            begin
            end
            ST_PUSH:
            begin
                load_out = !out_valid_reg || rsp.ready;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        ref_next = ref_reg;
        mod_next = mod_reg;
        cnt_next = cnt_reg;
        if (pop)
        begin
            unique case (cmd.op)
                OP_ACCESS:
                begin
                    if (period_hit)
                    begin
                        ref_next = '0;
                        cnt_next = '0;
                    end
                    else
                    begin
                        ref_next[blk] = 1'b1;
                        cnt_next      = cnt_inc;
                    end
                end
                OP_CLEAR:
                begin
                    ref_next = '0;
                end
                OP_DIRTY:
                begin
                    mod_next[blk] = cmd.dirty;
                end
                OP_VICTIM:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ref_reg       <= '0;
            mod_reg       <= '0;
            cnt_reg       <= '0;
            period_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ref_reg   <= ref_next;
            mod_reg   <= mod_next;
            cnt_reg   <= cnt_next;
            if (cfg_wr_en)
            begin
                period_reg <= cfg_wr_data;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start_scan)
        begin
            chunk_reg    <= '0;
            best_cls_reg <= CLS_NONE;
            best_idx_reg <= '0;
        end
        else if (state_reg == ST_SCAN)
        begin
            chunk_reg    <= chunk_reg + 1'b1;
            best_cls_reg <= scan_cls;
            best_idx_reg <= scan_idx;
        end
        if (load_out)
        begin
            out_idx_reg <= BLK_W'(best_idx_reg);
            out_cls_reg <= best_cls_reg[1:0];
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.victim_index = out_idx_reg;
    assign rsp.victim_class = out_cls_reg;

    `NRU_ASSERT_IMP(a_push_has_class, state_reg == ST_PUSH, best_cls_reg != CLS_NONE, "victim pushed without a class")
    `NRU_ASSERT_IMP(a_pop_idle, pop, state_reg == ST_IDLE, "command popped outside idle")
    `NRU_ASSERT_NXT(a_clear_refs, pop && (cmd.op == OP_CLEAR), ref_reg == '0, "invalidate left marks set")
    `NRU_ASSERT_NXT(a_period_wrap, pop && (cmd.op == OP_ACCESS) && period_hit, (cnt_reg == '0) && (ref_reg == '0), "period hit did not restart")
    `NRU_ASSERT_IMP(a_out_from_push, $rose(out_valid_reg), $past(state_reg) == ST_PUSH, "result raised outside push")

endmodule

`default_nettype wire

// ----- rtl/nru_replacement_policy_unit.sv -----
// NRU replacement policy unit: request beats enter a two-entry command queue and
// are carried out in order by the back end. Read, write, invalidate and set-dirty
// beats are applied as they are popped, and the back end stays idle for them. A
// victim query is popped, then scans the blocks eight at a time through the shared
// compare lanes, stopping early when a clean, unreferenced block turns up, and then
// loads the result beat once the previous one has been taken. Requests keep being
// accepted while the queue has room, including while a result beat waits.
// Depends on nru_pkg, nru_if, nru_front, nru_cmd_fifo and nru_back.
`default_nettype none

module nru_replacement_policy_unit
    import nru_pkg::*;
#(
    parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    nru_req_if.sink             req_ch,
    nru_rsp_if.source           rsp_ch,
    input  logic                cfg_wr_en,
    input  logic [PERIOD_W-1:0] cfg_wr_data
);

    nru_cmd_t       front_cmd;
    nru_cmd_t       head_cmd;
    nru_fifo_stat_t fifo_stat;
    logic           push;
    logic           pop;

    nru_front #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_front (
        .req  (req_ch),
        .stat (fifo_stat),
        .push (push),
        .cmd  (front_cmd)
    );

    nru_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (front_cmd),
        .pop      (pop),
        .head     (head_cmd),
        .stat     (fifo_stat)
    );

    nru_back #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (head_cmd),
        .stat        (fifo_stat),
        .pop         (pop),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .rsp         (rsp_ch)
    );

endmodule

`default_nettype wire

// ----- dv/tb_nru_replacement_policy_unit.sv -----
`timescale 1ns / 100ps
// Testbench for nru_replacement_policy_unit: random and directed request beats
// checked against a built-in NRU mark predictor. Depends on nru_pkg, nru_if and the RTL.

module tb_nru_replacement_policy_unit;
    import nru_pkg::*;

    localparam int BEATS_PER_PHASE = 90;
    localparam int SETTLE_CYCLES   = 24;
    localparam int BEHIND_READS    = 40;
    localparam int TOP_BLOCK       = NUM_BLOCKS_DEF - 1;
    localparam logic [REQ_TYPE_W-1:0] REQ_CODE_MAX = '1;

    typedef struct packed {
        logic [REQ_TYPE_W-1:0] kind;
        logic [BLK_W-1:0]      blk;
        logic                  dirty;
    } nru_beat_t;

    typedef struct packed {
        logic [BLK_W-1:0] victim_index;
        logic [1:0]       victim_class;
    } victim_t;

    logic                clk;
    logic                rst_n = 1'b0;
    logic                cfg_wr_en;
    logic [PERIOD_W-1:0] cfg_wr_data;

    nru_req_if req_ch ();
    nru_rsp_if rsp_ch ();

    nru_replacement_policy_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_ch      (req_ch),
        .rsp_ch      (rsp_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // predictor state
    logic [NUM_BLOCKS_DEF-1:0] refer_marks = '0;
    logic [NUM_BLOCKS_DEF-1:0] modif_marks = '0;
    logic [PERIOD_W-1:0]       access_cnt  = '0;
    logic [PERIOD_W-1:0]       clear_period = '0;

    nru_beat_t pending_beats[$];
    victim_t   victims_due[$];

    int req_issued      = 0;
    int req_accepted    = 0;
    int rsp_accepted    = 0;
    int rsp_seen        = 0;
    int req_gap         = 0;
    int rsp_stall       = 0;
    int req_idle_max    = 13;
    int rsp_idle_max    = 13;
    int mismatches      = 0;
    int periods_written = 0;

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic victim_t pick_victim();
        victim_t    best;
        int         best_class;
        logic [1:0] cls;
        best = '0;
        best_class = 4;
        for (int i = 0; i < NUM_BLOCKS_DEF; i++)
        begin
            cls = '0;
            cls[REFER] = refer_marks[i];
            cls[MODIF] = modif_marks[i];
            if (int'(cls) < best_class)
            begin
                best_class = int'(cls);
                best.victim_index = BLK_W'(i);
                best.victim_class = cls;
            end
        end
        return best;
    endfunction

    function automatic void apply_request_to_marks(nru_beat_t b);
        case (b.kind)
            REQ_READ, REQ_WRITE:
            begin
                if (int'(b.blk) < NUM_BLOCKS_DEF)
                begin
                    refer_marks[b.blk] = 1'b1;
                    access_cnt = access_cnt + 1'b1;
                    if (clear_period != '0 && access_cnt == clear_period)
                    begin
                        refer_marks = '0;
                        access_cnt = '0;
                    end
                end
            end
            REQ_INVALIDATE: refer_marks = '0;
            REQ_SET_DIRTY:
            begin
                if (int'(b.blk) < NUM_BLOCKS_DEF)
                    modif_marks[b.blk] = b.dirty;
            end
            REQ_VICTIM: victims_due.push_back(pick_victim());
            default: ;
        endcase
    endfunction

    // sample beats, run predictor, check results
    always @(posedge clk)
    begin : monitor
        nru_beat_t b;
        victim_t   want;
        if (rst_n)
        begin
            if (cfg_wr_en)
                clear_period = cfg_wr_data;
            if (req_ch.valid && req_ch.ready)
            begin
                b.kind  = req_ch.req_type;
                b.blk   = req_ch.block_index;
                b.dirty = req_ch.dirty_value;
                apply_request_to_marks(b);
                req_accepted++;
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                rsp_accepted++;
                if (victims_due.size() == 0)
                begin
                    $error("result beat with no victim query outstanding: index %0d class %0d",
                           rsp_ch.victim_index, rsp_ch.victim_class);
                    mismatches++;
                end
                else
                begin
                    want = victims_due.pop_front();
                    if (rsp_ch.victim_index !== want.victim_index)
                    begin
                        $error("victim_index expected %0d actual %0d",
                               want.victim_index, rsp_ch.victim_index);
                        mismatches++;
                    end
                    if (rsp_ch.victim_class !== want.victim_class)
                    begin
                        $error("victim_class expected %0d actual %0d",
                               want.victim_class, rsp_ch.victim_class);
                        mismatches++;
                    end
                end
            end
        end
    end

    // request driver: hold until accepted, then idle, then advance
    always @(negedge clk)
    begin : req_driver
        nru_beat_t b;
        if (rst_n && req_issued == req_accepted)
        begin
            if (req_gap > 0)
            begin
                req_ch.valid <= 1'b0;
                req_gap--;
            end
            else if (pending_beats.size() > 0)
            begin
                b = pending_beats.pop_front();
                req_ch.valid       <= 1'b1;
                req_ch.req_type    <= b.kind;
                req_ch.block_index <= b.blk;
                req_ch.dirty_value <= b.dirty;
                req_issued++;
                req_gap = $urandom_range(0, req_idle_max);
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // result sink: hold ready low for a random stall before each beat
    always @(negedge clk)
    begin : rsp_driver
        if (rst_n)
        begin
            if (rsp_seen != rsp_accepted)
            begin
                rsp_seen = rsp_accepted;
                rsp_stall = $urandom_range(0, rsp_idle_max);
            end
            if (rsp_stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                rsp_stall--;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    task automatic queue_beat(input logic [REQ_TYPE_W-1:0] kind, input int blk,
                              input logic dirty);
        nru_beat_t b;
        b.kind  = kind;
        b.blk   = BLK_W'(blk);
        b.dirty = dirty;
        pending_beats.push_back(b);
    endtask

    function automatic nru_beat_t random_beat();
        nru_beat_t b;
        int        r;
        r = $urandom_range(0, 99);
        b.blk = ($urandom_range(0, 1) == 0) ? BLK_W'($urandom_range(0, 7)) : BLK_W'($urandom);
        b.dirty = 1'($urandom);
        if (r < 30)
            b.kind = REQ_READ;
        else if (r < 50)
            b.kind = REQ_WRITE;
        else if (r < 70)
        begin
            b.kind = REQ_SET_DIRTY;
            b.dirty = ($urandom_range(0, 3) != 0);
        end
        else if (r < 88)
            b.kind = REQ_VICTIM;
        else if (r < 93)
            b.kind = REQ_INVALIDATE;
        else
            b.kind = REQ_TYPE_W'($urandom_range(int'(REQ_SET_DIRTY) + 1, int'(REQ_CODE_MAX)));
        return b;
    endfunction

    task automatic queue_random_phase(input int count);
        nru_beat_t b;
        int        useful;
        useful = 0;
        while (useful < count)
        begin
            b = random_beat();
            pending_beats.push_back(b);
            if (b.kind <= REQ_SET_DIRTY)
                useful++;
        end
    endtask

    task automatic wait_until_settled();
        while (pending_beats.size() != 0 || req_issued != req_accepted
               || victims_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_clear_period(input logic [PERIOD_W-1:0] value);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        periods_written++;
    endtask

    task automatic set_idling(input int phase);
        case (phase % 4)
            0: begin req_idle_max = 13; rsp_idle_max = 13; end
            1: begin req_idle_max = 0;  rsp_idle_max = 0;  end
            2: begin req_idle_max = 13; rsp_idle_max = 0;  end
            default: begin req_idle_max = 0; rsp_idle_max = 13; end
        endcase
    endtask

    initial
    begin : stimulus
        logic [PERIOD_W-1:0] periods[6];
        logic [PERIOD_W-1:0] behind;
        req_ch.valid       = 1'b0;
        req_ch.req_type    = REQ_READ;
        req_ch.block_index = '0;
        req_ch.dirty_value = 1'b0;
        rsp_ch.ready       = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_wr_data        = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed beats at the reset period of zero
        queue_beat(REQ_VICTIM, 0, 1'b0);
        queue_beat(REQ_SET_DIRTY, 0, 1'b1);
        queue_beat(REQ_VICTIM, TOP_BLOCK, 1'b1);
        queue_beat(REQ_READ, 1, 1'b0);
        queue_beat(REQ_WRITE, TOP_BLOCK, 1'b1);
        queue_beat(REQ_VICTIM, 0, 1'b0);
        queue_beat(REQ_SET_DIRTY, TOP_BLOCK, 1'b1);
        queue_beat(REQ_SET_DIRTY, 0, 1'b0);
        queue_beat(REQ_VICTIM, 0, 1'b0);
        queue_beat(REQ_INVALIDATE, TOP_BLOCK, 1'b1);
        queue_beat(REQ_VICTIM, 0, 1'b0);
        for (int k = int'(REQ_SET_DIRTY) + 1; k <= int'(REQ_CODE_MAX); k++)
            queue_beat(REQ_TYPE_W'(k), TOP_BLOCK, 1'b1);
        queue_beat(REQ_SET_DIRTY, 2, 1'b1);
        queue_beat(REQ_READ, 0, 1'b1);
        queue_beat(REQ_VICTIM, TOP_BLOCK, 1'b0);
        queue_beat(REQ_SET_DIRTY, 1, 1'b0);
        queue_beat(REQ_VICTIM, 0, 1'b1);
        wait_until_settled();

        periods[0] = 16'd1;
        periods[1] = 16'd5;
        periods[2] = 16'd0;
        periods[3] = 16'hFFFF;
        periods[4] = 16'd40;
        periods[5] = PERIOD_W'($urandom_range(3, 300));
        for (int p = 0; p < 6; p++)
        begin
            set_idling(p);
            write_clear_period(periods[p]);
            if (periods[p] == '0)
            begin
                queue_beat(REQ_READ, 3, 1'b0);
                queue_beat(REQ_WRITE, 4, 1'b1);
            end
            queue_random_phase(BEATS_PER_PHASE);
            wait_until_settled();
        end

        // drop the period just below the running count: no clear may fire
        // until the count wraps all the way round
        set_idling(1);
        if (access_cnt < 2)
        begin
            queue_beat(REQ_READ, 5, 1'b0);
            queue_beat(REQ_READ, 6, 1'b0);
            wait_until_settled();
        end
        behind = access_cnt - 1'b1;
        write_clear_period(behind);
        for (int i = 0; i < NUM_BLOCKS_DEF; i++)
            queue_beat(REQ_SET_DIRTY, i, 1'b1);
        for (int i = 0; i < BEHIND_READS; i++)
            queue_beat(REQ_READ, i % NUM_BLOCKS_DEF, 1'(i));
        queue_beat(REQ_VICTIM, 0, 1'b0);
        queue_beat(REQ_WRITE, TOP_BLOCK, 1'b0);
        queue_beat(REQ_VICTIM, 0, 1'b0);
        wait_until_settled();

        set_idling(0);
        write_clear_period(PERIOD_W'($urandom_range(2, 60)));
        queue_random_phase(BEATS_PER_PHASE);
        wait_until_settled();

        $display("Covered %0d request beats and %0d victim results over %0d period settings",
                 req_accepted, rsp_accepted, periods_written);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin : watchdog
        #4000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/nru_pkg.sv
rtl/nru_if.sv
rtl/nru_front.sv
rtl/nru_cmd_fifo.sv
rtl/nru_back.sv
rtl/nru_replacement_policy_unit.sv
dv/tb_nru_replacement_policy_unit.sv
